[design/gps_pkg.sv]
`timescale 1ns / 1ps

package gps_pkg;

    // Default values for the top level parameters
    localparam int MAX_GRID_DEF      = 64;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int PHASE_BITS_DEF    = 32;

    // Field widths
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 2;
    localparam int GRID_W   = 7;
    localparam int COORD_W  = 7;
    localparam int INDEX_W  = 18;
    localparam int TRIG_W   = 16;
    localparam int ROT_W    = 34;   // Q2.30 plus guard bits
    localparam int ANG_W    = 33;   // turns scaled by 2^32, signed

    localparam logic [GRID_W-1:0] GRID_SIZE_RST = 7'd16;

    // CORDIC constants
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN  = 34'sd652032875;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 33'sd2147483648;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_GRID_SIZE = 2'd0,
        REG_STEP_X    = 2'd1,
        REG_STEP_Y    = 2'd2,
        REG_STEP_Z    = 2'd3
    } gps_reg_t;

    // Rotation state carried through the CORDIC stages
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ANG_W-1:0] ang;
    } gps_rot_t;

    // Side data that rides along with the rotation
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               oor;
        logic               neg;
    } gps_side_t;

    // atan(2^-i) in turns scaled by 2^32, rounded
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] r;
        case (i)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10679838;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            24:      r = 32'd41;
            25:      r = 32'd20;
            26:      r = 32'd10;
            27:      r = 32'd5;
            28:      r = 32'd3;
            29:      r = 32'd1;
            30:      r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[design/gps_cfg.sv]
`timescale 1ns / 1ps

module gps_cfg #(
    parameter int MAX_GRID = gps_pkg::MAX_GRID_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gps_pkg::IDX_W-1:0]        cfg_index,
    input  logic [gps_pkg::CFG_W-1:0]        cfg_data,
    output logic [gps_pkg::GRID_W-1:0]       grid_n,
    output logic [gps_pkg::GRID_W-2:0]       grid_half,
    output logic signed [gps_pkg::CFG_W-1:0] step_x,
    output logic signed [gps_pkg::CFG_W-1:0] step_y,
    output logic signed [gps_pkg::CFG_W-1:0] step_z
);

    logic [gps_pkg::GRID_W-1:0] grid_size_reg;
    logic [gps_pkg::CFG_W-1:0]  step_x_reg;
    logic [gps_pkg::CFG_W-1:0]  step_y_reg;
    logic [gps_pkg::CFG_W-1:0]  step_z_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= gps_pkg::GRID_SIZE_RST;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            step_z_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (gps_pkg::gps_reg_t'(cfg_index))
                gps_pkg::REG_GRID_SIZE: grid_size_reg <= cfg_data[gps_pkg::GRID_W-1:0];
                gps_pkg::REG_STEP_X:    step_x_reg    <= cfg_data;
                gps_pkg::REG_STEP_Y:    step_y_reg    <= cfg_data;
                gps_pkg::REG_STEP_Z:    step_z_reg    <= cfg_data;
                default:                step_x_reg    <= step_x_reg;
            endcase
        end
    end

    // Grid size clamped to 1..MAX_GRID
    always_comb
    begin
        if (grid_size_reg == '0)
            grid_n = gps_pkg::GRID_W'(1);
        else if (int'(grid_size_reg) > MAX_GRID)
            grid_n = gps_pkg::GRID_W'(MAX_GRID);
        else
            grid_n = grid_size_reg;
    end

    assign grid_half = grid_n[gps_pkg::GRID_W-1:1];
    assign step_x    = $signed(step_x_reg);
    assign step_y    = $signed(step_y_reg);
    assign step_z    = $signed(step_z_reg);

endmodule

[design/gps_front.sv]
`timescale 1ns / 1ps

module gps_front #(
    parameter int PHASE_BITS = gps_pkg::PHASE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [gps_pkg::COORD_W-1:0] coord_x,
    input  logic signed [gps_pkg::COORD_W-1:0] coord_y,
    input  logic signed [gps_pkg::COORD_W-1:0] coord_z,
    input  logic [gps_pkg::GRID_W-1:0]        grid_n,
    input  logic [gps_pkg::GRID_W-2:0]        grid_half,
    input  logic signed [gps_pkg::CFG_W-1:0]  step_x,
    input  logic signed [gps_pkg::CFG_W-1:0]  step_y,
    input  logic signed [gps_pkg::CFG_W-1:0]  step_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output gps_pkg::gps_rot_t                 out_rot,
    output gps_pkg::gps_side_t                out_side
);

    localparam int KEEP_BITS = (PHASE_BITS < 32) ? PHASE_BITS : 32;
    localparam logic [31:0] PHASE_MASK = ~(32'hFFFF_FFFF >> KEEP_BITS);
    localparam int NN_W  = 2 * gps_pkg::GRID_W;
    localparam int SUM_W = 3 * gps_pkg::GRID_W + 1;

    // Stage 1: products, range check, wrapped coordinates
    logic                        s1_valid_reg;
    logic [31:0]                 s1_px_reg, s1_py_reg, s1_pz_reg;
    logic                        s1_oor_reg;
    logic [NN_W-1:0]             s1_w0n_reg, s1_w1n_reg;
    logic [gps_pkg::GRID_W-1:0]  s1_w2_reg;
    logic signed [38:0]          prod_x, prod_y, prod_z;
    logic                        oor_next;
    logic [gps_pkg::GRID_W-1:0]  w0, w1, w2;
    logic signed [7:0]           half_pos, half_neg;
    logic signed [7:0]           cx, cy, cz;

    // Stage 2: phase sum, linear index
    logic                        s2_valid_reg;
    logic [31:0]                 s2_phase_reg;
    gps_pkg::gps_side_t          s2_side_reg;
    logic [31:0]                 phase_next;
    logic [SUM_W-1:0]            idx_full;
    gps_pkg::gps_side_t          s2_side_next;

    // Stage 3: half-turn fold, CORDIC start vector
    logic                        s3_valid_reg;
    gps_pkg::gps_rot_t           s3_rot_reg;
    gps_pkg::gps_side_t          s3_side_reg;
    gps_pkg::gps_rot_t           s3_rot_next;
    gps_pkg::gps_side_t          s3_side_next;
    logic signed [gps_pkg::ANG_W-1:0] ang;

    logic s1_load, s2_load, s3_load;

    // Stage enables: a stage loads when empty or when its successor loads
    assign s3_load  = !s3_valid_reg || out_ready;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    // Stage 1 logic
    always_comb
    begin
        half_pos = $signed({2'b00, grid_half});
        half_neg = -half_pos;
        cx       = 8'(coord_x);
        cy       = 8'(coord_y);
        cz       = 8'(coord_z);
        oor_next = (cx > half_pos) || (cx < half_neg) ||
                   (cy > half_pos) || (cy < half_neg) ||
                   (cz > half_pos) || (cz < half_neg);
        w0 = coord_x[gps_pkg::COORD_W-1] ? 7'(coord_x + grid_n) : coord_x;
        w1 = coord_y[gps_pkg::COORD_W-1] ? 7'(coord_y + grid_n) : coord_y;
        w2 = coord_z[gps_pkg::COORD_W-1] ? 7'(coord_z + grid_n) : coord_z;
        prod_x = 39'(coord_x) * 39'(step_x);
        prod_y = 39'(coord_y) * 39'(step_y);
        prod_z = 39'(coord_z) * 39'(step_z);
    end

    // Stage 2 logic
    always_comb
    begin
        phase_next = (s1_px_reg + s1_py_reg + s1_pz_reg) & PHASE_MASK;
        idx_full   = SUM_W'(s1_w0n_reg) * SUM_W'(grid_n) + SUM_W'(s1_w1n_reg) +
                     SUM_W'(s1_w2_reg);
        s2_side_next.oor   = s1_oor_reg;
        s2_side_next.neg   = 1'b0;
        s2_side_next.index = s1_oor_reg ? '0 : idx_full[gps_pkg::INDEX_W-1:0];
    end

    // Stage 3 logic: fold phase into [-1/4, 1/4] turn
    always_comb
    begin
        ang          = $signed({s2_phase_reg[31], s2_phase_reg});
        s3_side_next = s2_side_reg;
        s3_rot_next.x = gps_pkg::CORDIC_GAIN;
        s3_rot_next.y = '0;
        if (ang > gps_pkg::QUARTER_TURN)
        begin
            s3_rot_next.ang  = ang - gps_pkg::HALF_TURN;
            s3_side_next.neg = 1'b1;
        end
        else if (ang < -gps_pkg::QUARTER_TURN)
        begin
            s3_rot_next.ang  = ang + gps_pkg::HALF_TURN;
            s3_side_next.neg = 1'b1;
        end
        else
        begin
            s3_rot_next.ang  = ang;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
            if (s3_load)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_px_reg  <= prod_x[31:0];
            s1_py_reg  <= prod_y[31:0];
            s1_pz_reg  <= prod_z[31:0];
            s1_oor_reg <= oor_next;
            s1_w0n_reg <= NN_W'(w0) * NN_W'(grid_n);
            s1_w1n_reg <= NN_W'(w1) * NN_W'(grid_n);
            s1_w2_reg  <= w2;
        end
        if (s2_load)
        begin
            s2_phase_reg <= phase_next;
            s2_side_reg  <= s2_side_next;
        end
        if (s3_load)
        begin
            s3_rot_reg  <= s3_rot_next;
            s3_side_reg <= s3_side_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_rot   = s3_rot_reg;
    assign out_side  = s3_side_reg;

endmodule

[design/gps_cordic_stage.sv]
`timescale 1ns / 1ps

module gps_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gps_pkg::gps_rot_t  in_rot,
    input  gps_pkg::gps_side_t in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output gps_pkg::gps_rot_t  out_rot,
    output gps_pkg::gps_side_t out_side
);

    localparam logic signed [gps_pkg::ANG_W-1:0] ATAN =
        $signed({1'b0, gps_pkg::atan_turn(SHIFT)});

    logic               valid_reg;
    gps_pkg::gps_rot_t  rot_reg;
    gps_pkg::gps_side_t side_reg;
    gps_pkg::gps_rot_t  rot_next;
    logic signed [gps_pkg::ROT_W-1:0] x_sh, y_sh;
    logic               load;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // One micro-rotation toward zero residual angle
    always_comb
    begin
        x_sh = $signed(in_rot.x) >>> SHIFT;
        y_sh = $signed(in_rot.y) >>> SHIFT;
        if (!in_rot.ang[gps_pkg::ANG_W-1])
        begin
            rot_next.x   = in_rot.x - y_sh;
            rot_next.y   = in_rot.y + x_sh;
            rot_next.ang = in_rot.ang - ATAN;
        end
        else
        begin
            rot_next.x   = in_rot.x + y_sh;
            rot_next.y   = in_rot.y - x_sh;
            rot_next.ang = in_rot.ang + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rot_reg  <= rot_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;
    assign out_side  = side_reg;

endmodule

[design/gps_out.sv]
`timescale 1ns / 1ps

module gps_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  gps_pkg::gps_rot_t                 in_rot,
    input  gps_pkg::gps_side_t                in_side,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gps_pkg::INDEX_W-1:0]       grid_index,
    output logic signed [gps_pkg::TRIG_W-1:0] sine,
    output logic signed [gps_pkg::TRIG_W-1:0] cosine,
    output logic                              out_of_range
);

    localparam int WIDE_W = gps_pkg::ROT_W + 1;
    localparam int Q_W    = WIDE_W - 15;

    // Q2.30 to Q1.15: round half up, then saturate
    function automatic logic signed [gps_pkg::TRIG_W-1:0] to_q15(
        input logic signed [gps_pkg::ROT_W-1:0] v
    );
        logic signed [WIDE_W-1:0] t;
        logic signed [Q_W-1:0]    r;
        logic signed [gps_pkg::TRIG_W-1:0] q;
        t = WIDE_W'(v) + $signed(WIDE_W'(1 << 14));
        r = Q_W'(t >>> 15);
        if (r > $signed(Q_W'(32767)))
            q = 16'sh7FFF;
        else if (r < -$signed(Q_W'(32768)))
            q = 16'sh8000;
        else
            q = r[gps_pkg::TRIG_W-1:0];
        return q;
    endfunction

    logic                              valid_reg;
    logic [gps_pkg::INDEX_W-1:0]       index_reg;
    logic signed [gps_pkg::TRIG_W-1:0] sine_reg, cosine_reg;
    logic                              oor_reg;
    logic signed [gps_pkg::ROT_W-1:0]  x_fix, y_fix;
    logic                              load;

    assign load     = !valid_reg || !out_stall;
    assign in_ready = load;

    // Undo the half-turn fold
    always_comb
    begin
        x_fix = in_side.neg ? -in_rot.x : in_rot.x;
        y_fix = in_side.neg ? -in_rot.y : in_rot.y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg  <= in_side.index;
            oor_reg    <= in_side.oor;
            sine_reg   <= to_q15(y_fix);
            cosine_reg <= to_q15(x_fix);
        end
    end

    assign out_valid    = valid_reg;
    assign grid_index   = index_reg;
    assign sine         = sine_reg;
    assign cosine       = cosine_reg;
    assign out_of_range = oor_reg;

endmodule

[design/grid_phase_sincos_top.sv]
`timescale 1ns / 1ps

// Plane-wave phase factor for one grid point. Each item (coord_x, coord_y, coord_z)
// gives phase = sum of coord * step (turns scaled by 2^32, wrapping), its sine and
// cosine in Q1.15 from a CORDIC rotation, and the wrapped linear index
// x*n*n + y*n + z with n the grid size clamped to 1..MAX_GRID. A coordinate outside
// +/- n/2 sets out_of_range and forces the index to zero. The block takes one item
// per cycle unless stalled; the pipeline has three front stages for products,
// phase sum and angle fold, one register per CORDIC iteration and one output
// register. Empty stages collapse, so a stall on the output side holds back the
// input only once every stage is occupied. Write configuration only when idle.

module grid_phase_sincos_top #(
    parameter int MAX_GRID      = gps_pkg::MAX_GRID_DEF,
    parameter int CORDIC_STAGES = gps_pkg::CORDIC_STAGES_DEF,
    parameter int PHASE_BITS    = gps_pkg::PHASE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gps_pkg::IDX_W-1:0]         cfg_index,
    input  logic [gps_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [gps_pkg::COORD_W-1:0] coord_x,
    input  logic signed [gps_pkg::COORD_W-1:0] coord_y,
    input  logic signed [gps_pkg::COORD_W-1:0] coord_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gps_pkg::INDEX_W-1:0]       grid_index,
    output logic signed [gps_pkg::TRIG_W-1:0] sine,
    output logic signed [gps_pkg::TRIG_W-1:0] cosine,
    output logic                              out_of_range
);

    logic [gps_pkg::GRID_W-1:0]       grid_n;
    logic [gps_pkg::GRID_W-2:0]       grid_half;
    logic signed [gps_pkg::CFG_W-1:0] step_x, step_y, step_z;
    logic                             front_ready;

    gps_pkg::gps_rot_t  rot   [0:CORDIC_STAGES];
    gps_pkg::gps_side_t side  [0:CORDIC_STAGES];
    logic               vld   [0:CORDIC_STAGES];
    logic               rdy   [0:CORDIC_STAGES];

    // Configuration registers
    gps_cfg #(
        .MAX_GRID (MAX_GRID)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grid_n    (grid_n),
        .grid_half (grid_half),
        .step_x    (step_x),
        .step_y    (step_y),
        .step_z    (step_z)
    );

    // Phase, index and angle fold
    gps_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .grid_n    (grid_n),
        .grid_half (grid_half),
        .step_x    (step_x),
        .step_y    (step_y),
        .step_z    (step_z),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_rot   (rot[0]),
        .out_side  (side[0])
    );

    assign in_stall = !front_ready;

    // CORDIC rotation, one stage per iteration
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        gps_cordic_stage #(
            .SHIFT (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_rot    (rot[i]),
            .in_side   (side[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_rot   (rot[i+1]),
            .out_side  (side[i+1])
        );
    end

    // Rounding, saturation and output register
    gps_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vld[CORDIC_STAGES]),
        .in_ready     (rdy[CORDIC_STAGES]),
        .in_rot       (rot[CORDIC_STAGES]),
        .in_side      (side[CORDIC_STAGES]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .grid_index   (grid_index),
        .sine         (sine),
        .cosine       (cosine),
        .out_of_range (out_of_range)
    );

    // Input is held back only when a finished item is stuck at the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output side is free");

    // Out-of-range items carry a zero index
    a_oor_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (grid_index == '0))
        else $error("out-of-range item with nonzero index");

    // Unit vector: sine or cosine must be large
    a_unit_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sine > 16'sd16384 || sine < -16'sd16384 ||
                       cosine > 16'sd16384 || cosine < -16'sd16384))
        else $error("sine/cosine magnitude too small");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int          LATENCY     = gps_pkg::CORDIC_STAGES_DEF + 4;
    localparam int          STAGES      = gps_pkg::CORDIC_STAGES_DEF;
    localparam int          GRID_MAX    = gps_pkg::MAX_GRID_DEF;
    localparam int          STALL_LIMIT = 3000;
    localparam longint      ROT_GAIN    = 64'sd652032875;
    localparam int          PHASES      = 10;
    localparam int          PHASE_ITEMS = 110;

    typedef logic signed [gps_pkg::COORD_W-1:0] coord_t;

    typedef struct {
        logic [gps_pkg::INDEX_W-1:0]        grid_index;
        logic signed [gps_pkg::TRIG_W-1:0]  sine;
        logic signed [gps_pkg::TRIG_W-1:0]  cosine;
        logic                               out_of_range;
    } point_result_t;

    // atan(2^-i) in turns scaled by 2^32, rounded
    localparam longint ATAN_LUT [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               cfg_we       = 1'b0;
    logic [gps_pkg::IDX_W-1:0]          cfg_index    = gps_pkg::REG_GRID_SIZE;
    logic [gps_pkg::CFG_W-1:0]          cfg_data     = '0;
    logic                               in_valid     = 1'b0;
    logic                               in_stall;
    coord_t                             coord_x      = '0;
    coord_t                             coord_y      = '0;
    coord_t                             coord_z      = '0;
    logic                               out_valid;
    logic                               out_stall    = 1'b0;
    logic [gps_pkg::INDEX_W-1:0]        grid_index;
    logic signed [gps_pkg::TRIG_W-1:0]  sine;
    logic signed [gps_pkg::TRIG_W-1:0]  cosine;
    logic                               out_of_range;

    // Mirror of the configuration registers
    logic [gps_pkg::GRID_W-1:0]         grid_cfg;
    logic signed [31:0]                 step_cfg [3];

    point_result_t             expected_points [$];
    int                        mismatches   = 0;
    bit                        steady_in    = 1'b0;
    bit                        steady_out   = 1'b0;
    int unsigned               stall_left   = 0;

    grid_phase_sincos_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .grid_index   (grid_index),
        .sine         (sine),
        .cosine       (cosine),
        .out_of_range (out_of_range)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint eff_grid();
        longint n;
        n = longint'(grid_cfg);
        if (n < 1)
            n = 1;
        if (n > GRID_MAX)
            n = GRID_MAX;
        return n;
    endfunction

    // Round a Q2.30 value to Q1.15 with saturation
    function automatic logic signed [gps_pkg::TRIG_W-1:0] round_q15(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[gps_pkg::TRIG_W-1:0];
    endfunction

    // Phase factor and wrapped index for one grid point
    function automatic point_result_t plane_wave_point(coord_t cx, coord_t cy, coord_t cz);
        point_result_t r;
        longint        c [3];
        longint        w [3];
        longint        n, half, sum, ang, x, y, nx, idx;
        logic [31:0]   phase;
        bit            flip, outside;
        n = eff_grid();
        half = n / 2;
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        outside = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (c[k] > half || c[k] < -half)
                outside = 1'b1;
            w[k] = (c[k] < 0) ? c[k] + n : c[k];
        end

        sum = c[0] * longint'(step_cfg[0]) + c[1] * longint'(step_cfg[1]) +
              c[2] * longint'(step_cfg[2]);
        phase = sum[31:0];

        // fold into [-1/4, 1/4] turn, negate at the end
        ang = longint'($signed(phase));
        flip = 1'b0;
        if (ang > 64'sd1073741824)
        begin
            ang = ang - 64'sd2147483648;
            flip = 1'b1;
        end
        else if (ang < -64'sd1073741824)
        begin
            ang = ang + 64'sd2147483648;
            flip = 1'b1;
        end

        x = ROT_GAIN;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (ang >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                ang = ang - ATAN_LUT[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                ang = ang + ATAN_LUT[i];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end

        idx = w[0] * n * n + w[1] * n + w[2];
        r.grid_index   = outside ? '0 : idx[gps_pkg::INDEX_W-1:0];
        r.sine         = round_q15(y);
        r.cosine       = round_q15(x);
        r.out_of_range = outside;
        return r;
    endfunction

    // Output side back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (!steady_out)
            stall_left = gap_len();
        out_stall <= (stall_left != 0);
    end

    // Result check; values are stable at the falling edge before acceptance
    always @(negedge clk)
    begin
        point_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result index %0d sine %0d cosine %0d oor %0b",
                         $time, grid_index, sine, cosine, out_of_range);
                mismatches++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (grid_index !== want.grid_index)
                begin
                    $display("%0t: grid_index expected %0d got %0d",
                             $time, want.grid_index, grid_index);
                    mismatches++;
                end
                if (sine !== want.sine)
                begin
                    $display("%0t: sine expected %0d got %0d", $time, want.sine, sine);
                    mismatches++;
                end
                if (cosine !== want.cosine)
                begin
                    $display("%0t: cosine expected %0d got %0d", $time, want.cosine, cosine);
                    mismatches++;
                end
                if (out_of_range !== want.out_of_range)
                begin
                    $display("%0t: out_of_range expected %0b got %0b",
                             $time, want.out_of_range, out_of_range);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles in a row with no item moving on either side
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Send one grid point, record its expected result on acceptance
    task automatic send_point(coord_t cx, coord_t cy, coord_t cz);
        int unsigned gap;
        gap = steady_in ? 0 : gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coord_x  <= cx;
        coord_y  <= cy;
        coord_z  <= cz;
        in_valid <= 1'b1;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        expected_points.push_back(plane_wave_point(cx, cy, cz));
        @(posedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Write all four registers while the block is idle
    task automatic load_config(logic [gps_pkg::GRID_W-1:0] gs, logic [31:0] sx,
                               logic [31:0] sy, logic [31:0] sz);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_index <= gps_pkg::REG_GRID_SIZE;
        // upper bits of the data word are don't-care for the grid size
        cfg_data  <= {25'($urandom), gs};
        @(posedge clk);
        cfg_index <= gps_pkg::REG_STEP_X;
        cfg_data  <= sx;
        @(posedge clk);
        cfg_index <= gps_pkg::REG_STEP_Y;
        cfg_data  <= sy;
        @(posedge clk);
        cfg_index <= gps_pkg::REG_STEP_Z;
        cfg_data  <= sz;
        @(posedge clk);
        cfg_we      <= 1'b0;
        grid_cfg    = gs;
        step_cfg[0] = sx;
        step_cfg[1] = sy;
        step_cfg[2] = sz;
    endtask

    // Reset values: grid of 16, zero phase, so cosine saturates to 32767
    task automatic test_reset_defaults();
        send_point(7'sd0, 7'sd0, 7'sd0);
        send_point(7'sd8, -7'sd8, 7'sd8);
        send_point(-7'sd1, 7'sd3, -7'sd8);
        send_point(7'sd9, 7'sd0, 7'sd0);
    endtask

    // Quarter, half and three-quarter turns, and the step extremes
    task automatic test_phase_extremes();
        load_config(7'd64, 32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(7'sd1, 7'sd0, 7'sd0);
        send_point(7'sd2, 7'sd0, 7'sd0);
        send_point(-7'sd1, 7'sd0, 7'sd0);
        send_point(7'sd3, 7'sd0, 7'sd0);
        send_point(7'sd0, 7'sd1, 7'sd0);
        send_point(7'sd0, -7'sd1, 7'sd0);
        send_point(7'sd0, 7'sd0, 7'sd1);
        send_point(7'sd0, 7'sd0, -7'sd1);
        send_point(7'sd32, 7'sd32, 7'sd32);
        send_point(-7'sd32, -7'sd32, -7'sd32);
        send_point(7'sd63, coord_t'(-64), 7'sd0);
    endtask

    // Grid size clamping at both ends, largest index
    task automatic test_grid_clamp();
        load_config(7'd0, 32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF);
        send_point(7'sd0, 7'sd0, 7'sd0);
        send_point(7'sd1, 7'sd0, 7'sd0);
        send_point(7'sd0, 7'sd0, -7'sd1);
        load_config(7'd127, 32'h0123_4567, 32'hF00D_0001, 32'h8000_0001);
        send_point(7'sd32, -7'sd32, 7'sd31);
        send_point(-7'sd33, 7'sd0, 7'sd0);
        send_point(-7'sd1, -7'sd1, -7'sd1);
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return {3'($urandom_range(0, 7)), 29'h0};
            4:       return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic coord_t pick_coord();
        int half, v;
        half = int'(eff_grid() / 2);
        if ($urandom_range(0, 99) < 80)
            v = int'($urandom_range(0, 2 * half)) - half;
        else
            v = int'($urandom_range(0, 127));
        return v[gps_pkg::COORD_W-1:0];
    endfunction

    // Random points under a series of settings
    task automatic test_random_points();
        logic [gps_pkg::GRID_W-1:0] gs;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       gs = 7'd1;
                1:       gs = 7'd64;
                2:       gs = 7'd127;
                3:       gs = 7'd0;
                4:       gs = 7'd2;
                default: gs = ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                           : 7'($urandom_range(2, 64));
            endcase
            load_config(gs, pick_step(), pick_step(), pick_step());
            steady_in  = (p % 4 == 1);
            steady_out = (p % 4 == 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_point(pick_coord(), pick_coord(), pick_coord());
            steady_in  = 1'b0;
            steady_out = 1'b0;
        end
    endtask

    initial
    begin
        grid_cfg    = gps_pkg::GRID_SIZE_RST;
        step_cfg[0] = '0;
        step_cfg[1] = '0;
        step_cfg[2] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_phase_extremes();
        test_grid_clamp();
        test_random_points();

        drain_pipeline();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
